FILE: sv/mfit_pkg.sv
// Package for the modular factorial / inverse table block.
// Holds request and result payload types, control codes and the
// controller-to-datapath command and status structs. No dependencies.
package mfit_pkg;

  localparam int WORD_W         = 32;
  localparam int IDX_W          = 12;
  localparam int MAXN_W         = 12;
  localparam int TABLE_DEPTH_DEF = 4096;
  localparam int EXTRA_ENTRIES  = 32;
  localparam logic [WORD_W-1:0] MODULUS_RESET = 32'd998244353;
  localparam logic [MAXN_W-1:0] MAXN_RESET    = 12'd4064;

  typedef enum logic {
    MODE_BUILD = 1'b0,
    MODE_QUERY = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_BUILT = 2'd1,
    STATUS_RANGE     = 2'd2
  } status_t;

  typedef enum logic {
    REG_MODULUS = 1'b0,
    REG_MAX_N   = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic             mode;
    logic [IDX_W-1:0] index;
  } req_t;

  typedef struct packed {
    logic [WORD_W-1:0] factorial;
    logic [WORD_W-1:0] inverse_factorial;
    logic [WORD_W-1:0] inverse;
    logic [1:0]        status;
  } resp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ENTRY,
    ST_DIV,
    ST_RDINV,
    ST_MLOAD,
    ST_MUL,
    ST_MSTORE,
    ST_WRITE,
    ST_BDONE,
    ST_QOUT
  } state_t;

  typedef enum logic [1:0] {
    MS_INV,
    MS_FAC,
    MS_IFAC
  } mul_sel_t;

  typedef enum logic [1:0] {
    WR_NONE,
    WR_ZERO,
    WR_LOW,
    WR_CALC
  } wr_kind_t;

  typedef struct packed {
    logic     q_read;
    logic     build_init;
    logic     div_load;
    logic     div_step;
    logic     inv_rd;
    logic     mul_load;
    logic     mul_step;
    logic     mul_phase;
    logic     mul_store;
    mul_sel_t mul_sel;
    wr_kind_t wr_kind;
    logic     build_done;
    logic     show_query;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic m_small;
    logic i_ge_m;
    logic i_lt2;
  } dp_stat_t;

endpackage

FILE: sv/mfit_ctrl.sv
// Sequencer for table build and query read-out.
// Depends on mfit_pkg for state, command and status types.
module mfit_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                mode,
  input  mfit_pkg::dp_stat_t  stat,
  output mfit_pkg::dp_cmd_t   cmd,
  output logic                busy,
  output logic                strobe
);

  mfit_pkg::state_t   state_r, state_nxt;
  mfit_pkg::mul_sel_t sel_r, sel_nxt;
  logic [5:0]         cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mfit_pkg::ST_IDLE;
      sel_r   <= mfit_pkg::MS_INV;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    sel_nxt     = sel_r;
    cnt_nxt     = cnt_r;
    cmd         = '0;
    cmd.mul_sel = sel_r;
    cmd.wr_kind = mfit_pkg::WR_NONE;
    cmd.mul_phase = cnt_r[0];
    busy        = (state_r != mfit_pkg::ST_IDLE);
    strobe      = 1'b0;
    unique case (state_r)
      mfit_pkg::ST_IDLE: begin
        if (start) begin
          if (mode == mfit_pkg::MODE_QUERY) begin
            cmd.q_read = 1'b1;
            state_nxt  = mfit_pkg::ST_QOUT;
          end else begin
            cmd.build_init = 1'b1;
            state_nxt      = mfit_pkg::ST_ENTRY;
          end
        end
      end
      mfit_pkg::ST_ENTRY: begin
        if (stat.done) begin
          state_nxt = mfit_pkg::ST_BDONE;
        end else if (stat.m_small || stat.i_ge_m) begin
          cmd.wr_kind = mfit_pkg::WR_ZERO;
        end else if (stat.i_lt2) begin
          cmd.wr_kind = mfit_pkg::WR_LOW;
        end else begin
          cmd.div_load = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = mfit_pkg::ST_DIV;
        end
      end
      mfit_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 6'd1;
        if (cnt_r == 6'd31) begin
          state_nxt = mfit_pkg::ST_RDINV;
        end
      end
      mfit_pkg::ST_RDINV: begin
        cmd.inv_rd = 1'b1;
        sel_nxt    = mfit_pkg::MS_INV;
        state_nxt  = mfit_pkg::ST_MLOAD;
      end
      mfit_pkg::ST_MLOAD: begin
        cmd.mul_load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = mfit_pkg::ST_MUL;
      end
      mfit_pkg::ST_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_nxt      = cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          state_nxt = mfit_pkg::ST_MSTORE;
        end
      end
      mfit_pkg::ST_MSTORE: begin
        cmd.mul_store = 1'b1;
        case (sel_r)
          mfit_pkg::MS_INV: begin
            sel_nxt   = mfit_pkg::MS_FAC;
            state_nxt = mfit_pkg::ST_MLOAD;
          end
          mfit_pkg::MS_FAC: begin
            sel_nxt   = mfit_pkg::MS_IFAC;
            state_nxt = mfit_pkg::ST_MLOAD;
          end
          default: begin
            state_nxt = mfit_pkg::ST_WRITE;
          end
        endcase
      end
      mfit_pkg::ST_WRITE: begin
        cmd.wr_kind = mfit_pkg::WR_CALC;
        state_nxt   = mfit_pkg::ST_ENTRY;
      end
      mfit_pkg::ST_BDONE: begin
        cmd.build_done = 1'b1;
        strobe         = 1'b1;
        state_nxt      = mfit_pkg::ST_IDLE;
      end
      mfit_pkg::ST_QOUT: begin
        cmd.show_query = 1'b1;
        strobe         = 1'b1;
        state_nxt      = mfit_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = mfit_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/mfit_dpath.sv
// Datapath: table memories, restoring divider, shift-add modular multiplier.
// Depends on mfit_pkg for payload, command and status types.
module mfit_dpath #(
  parameter int TABLE_DEPTH = mfit_pkg::TABLE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  mfit_pkg::dp_cmd_t                  cmd,
  input  mfit_pkg::req_t                     req,
  input  logic [mfit_pkg::WORD_W-1:0]        modulus,
  input  logic [mfit_pkg::MAXN_W-1:0]        max_n,
  output mfit_pkg::dp_stat_t                 stat,
  output mfit_pkg::resp_t                    resp
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = AW + 1;
  localparam int W  = mfit_pkg::WORD_W;
  localparam logic [31:0] DEPTH32 = 32'(TABLE_DEPTH);

  logic [W-1:0] fac_mem  [TABLE_DEPTH];
  logic [W-1:0] ifac_mem [TABLE_DEPTH];
  logic [W-1:0] inv_mem  [TABLE_DEPTH];

  logic [W-1:0]  m_r;
  logic [CW-1:0] n_r, i_r, built_r;
  logic [W-1:0]  dvd_r, q_r;
  logic [CW-1:0] rem_r;
  logic [W-1:0]  acc_r, ma_r, mb_r;
  logic [W-1:0]  inv_i_r, fac_r, ifac_r;
  logic [W-1:0]  fac_rd_r, ifac_rd_r, inv_rd_r;
  logic [1:0]    qstat_r;

  logic [31:0]   want32, idx32;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [CW-1:0] div_sh, div_sub;
  logic          div_ge;
  logic [W:0]    dbl, dbl_sub, add, add_sub;
  logic [W-1:0]  wr_fac, wr_ifac, wr_inv;

  assign want32  = 32'(max_n) + 32'(mfit_pkg::EXTRA_ENTRIES);
  assign idx32   = 32'(req.index);
  assign wr_addr = i_r[AW-1:0];
  assign rd_addr = cmd.q_read ? idx32[AW-1:0] : rem_r[AW-1:0];

  assign stat.done    = (i_r == n_r);
  assign stat.m_small = (m_r < 32'd2);
  assign stat.i_ge_m  = (32'(i_r) >= m_r);
  assign stat.i_lt2   = (i_r < CW'(2));

  // restoring division step
  assign div_sh  = {rem_r[AW-1:0], dvd_r[W-1]};
  assign div_ge  = (div_sh >= i_r);
  assign div_sub = div_sh - i_r;

  // modular shift-add step: double on even phase, add on odd
  assign dbl     = {acc_r, 1'b0};
  assign dbl_sub = dbl - {1'b0, m_r};
  assign add     = {1'b0, acc_r} + {1'b0, ma_r};
  assign add_sub = add - {1'b0, m_r};

  always_comb begin
    wr_fac  = fac_r;
    wr_ifac = ifac_r;
    wr_inv  = inv_i_r;
    case (cmd.wr_kind)
      mfit_pkg::WR_ZERO: begin
        wr_fac  = '0;
        wr_ifac = '0;
        wr_inv  = '0;
      end
      mfit_pkg::WR_LOW: begin
        wr_fac  = W'(1);
        wr_ifac = W'(1);
        wr_inv  = W'(i_r[0]);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_kind != mfit_pkg::WR_NONE) begin
      fac_mem[wr_addr]  <= wr_fac;
      ifac_mem[wr_addr] <= wr_ifac;
      inv_mem[wr_addr]  <= wr_inv;
    end
    if (cmd.q_read) begin
      fac_rd_r  <= fac_mem[rd_addr];
      ifac_rd_r <= ifac_mem[rd_addr];
    end
    if (cmd.q_read || cmd.inv_rd) begin
      inv_rd_r <= inv_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      built_r <= '0;
    end else if (cmd.build_done) begin
      built_r <= n_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.build_init) begin
      m_r <= modulus;
      n_r <= (want32 > DEPTH32) ? DEPTH32[CW-1:0] : want32[CW-1:0];
      i_r <= '0;
    end else if (cmd.wr_kind != mfit_pkg::WR_NONE) begin
      i_r <= i_r + CW'(1);
    end
    if (cmd.q_read) begin
      if (built_r == '0) begin
        qstat_r <= mfit_pkg::STATUS_NOT_BUILT;
      end else if (idx32 >= 32'(built_r)) begin
        qstat_r <= mfit_pkg::STATUS_RANGE;
      end else begin
        qstat_r <= mfit_pkg::STATUS_OK;
      end
    end
    if (cmd.div_load) begin
      dvd_r <= m_r;
      rem_r <= '0;
      q_r   <= '0;
    end else if (cmd.div_step) begin
      dvd_r <= {dvd_r[W-2:0], 1'b0};
      rem_r <= div_ge ? div_sub : div_sh;
      q_r   <= {q_r[W-2:0], div_ge};
    end
    if (cmd.mul_load) begin
      acc_r <= '0;
      case (cmd.mul_sel)
        mfit_pkg::MS_INV: begin
          ma_r <= m_r - q_r;
          mb_r <= inv_rd_r;
        end
        mfit_pkg::MS_FAC: begin
          ma_r <= fac_r;
          mb_r <= W'(i_r);
        end
        default: begin
          ma_r <= ifac_r;
          mb_r <= inv_i_r;
        end
      endcase
    end else if (cmd.mul_step) begin
      if (!cmd.mul_phase) begin
        acc_r <= (dbl >= {1'b0, m_r}) ? dbl_sub[W-1:0] : dbl[W-1:0];
      end else begin
        if (mb_r[W-1]) begin
          acc_r <= (add >= {1'b0, m_r}) ? add_sub[W-1:0] : add[W-1:0];
        end
        mb_r <= {mb_r[W-2:0], 1'b0};
      end
    end
    if (cmd.mul_store) begin
      case (cmd.mul_sel)
        mfit_pkg::MS_INV: inv_i_r <= acc_r;
        mfit_pkg::MS_FAC: fac_r   <= acc_r;
        default:          ifac_r  <= acc_r;
      endcase
    end else if (cmd.wr_kind == mfit_pkg::WR_ZERO || cmd.wr_kind == mfit_pkg::WR_LOW) begin
      fac_r  <= wr_fac;
      ifac_r <= wr_ifac;
    end
  end

  always_comb begin
    resp = '0;
    if (cmd.show_query) begin
      resp.status = qstat_r;
      if (qstat_r == mfit_pkg::STATUS_OK) begin
        resp.factorial         = fac_rd_r;
        resp.inverse_factorial = ifac_rd_r;
        resp.inverse           = inv_rd_r;
      end
    end
  end

endmodule

FILE: sv/modular_factorial_inverse_tables.sv
// Top level of the modular factorial / inverse table block.
// Depends on mfit_pkg, mfit_ctrl and mfit_dpath.
//
// Usage:
//   Request channel: a request (mode, index) is taken at a rising edge with
//   start high and busy low. Mode build recomputes the inverse, factorial and
//   inverse-factorial tables for entries 0 .. max_n+31 (capped at the table
//   depth); mode query reads the three values at one index.
//   Result channel: each request gives exactly one result, on out_resp for a
//   single cycle with out_strobe high. The receiver cannot stall; it must
//   take the result in that cycle.
//   Sequencing: a query shows its result in the cycle after it is taken;
//   busy stays high through that cycle and drops after it. A build walks
//   the entries one at a time with the single shared divider and multiplier;
//   an entry computed by recurrence takes one divider load, 32 divider steps
//   for modulus div i, one read of the earlier inverse, three 64-step shift-add
//   modular multiplies with a load and a store step each, and one table write.
//   Entries 0, 1, entries at or above the modulus, and all entries under a
//   modulus below two skip the divide and the multiplies.
//   Reset: the registers return to modulus 998244353 and max_n 4064, and the
//   block reports "not built" until the first build ends. Table memories are
//   not cleared; queries never reach entries beyond the built count.
//   Configuration: APB writes land at once; they only affect the next build.
module modular_factorial_inverse_tables #(
  parameter int TABLE_DEPTH = mfit_pkg::TABLE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  mfit_pkg::req_t                in_req,
  output logic                          out_strobe,
  output mfit_pkg::resp_t               out_resp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  logic [mfit_pkg::WORD_W-1:0] modulus_r;
  logic [mfit_pkg::MAXN_W-1:0] max_n_r;
  logic                        cfg_wr;
  mfit_pkg::reg_idx_t          cfg_sel;
  mfit_pkg::dp_cmd_t           cmd;
  mfit_pkg::dp_stat_t          stat;

  // Register file: word address picks the register, byte bits are ignored.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = mfit_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= mfit_pkg::MODULUS_RESET;
      max_n_r   <= mfit_pkg::MAXN_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        mfit_pkg::REG_MODULUS: modulus_r <= pwdata;
        mfit_pkg::REG_MAX_N:   max_n_r   <= pwdata[mfit_pkg::MAXN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      mfit_pkg::REG_MODULUS: prdata = modulus_r;
      mfit_pkg::REG_MAX_N:   prdata = 32'(max_n_r);
      default:               prdata = '0;
    endcase
  end

  // Sequencer: busy is high from the accepting edge through the result cycle.
  mfit_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .mode   (in_req.mode),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy),
    .strobe (out_strobe)
  );

  // Memories, divider and modular multiplier.
  mfit_dpath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dpath (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .req     (in_req),
    .modulus (modulus_r),
    .max_n   (max_n_r),
    .stat    (stat),
    .resp    (out_resp)
  );

endmodule
